// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros shared by the RTL that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ATM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ATM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/atm_pkg.sv -----
// Shared types, widths, coefficient tables and constant helpers of the tone mapper.
// No dependencies.
`default_nettype none

package atm_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int COEF_BITS         = 30;
  localparam int FIELD_W           = 24;
  localparam int BYTE_W            = 8;
  localparam int MODE_W            = 2;
  localparam int UW                = 25;  // channel value after the input stage
  localparam int AW                = 27;  // scaled channel inside the curve
  localparam int IW                = 27;  // inner sum of the curve
  localparam int PW                = 52;  // curve product
  localparam int NW                = 54;  // signed numerator
  localparam int DW                = 53;  // divider operands
  localparam int KW                = 32;  // unsigned curve factors
  localparam int MW                = 25;  // linear curve terms
  localparam int CW                = 49;  // constant curve terms
  localparam int CINW              = 31;  // input matrix coefficients
  localparam int COUTW             = 32;  // signed output matrix coefficients
  localparam int DIV_INT_BITS      = 2;   // integer bits of the quotient

  typedef enum logic [MODE_W-1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_FIT    = 2'd1,
    MODE_APPROX = 2'd2
  } tone_mode_t;

  typedef struct packed {
    tone_mode_t          mode;
    logic [BYTE_W-1:0]   alpha;
  } atm_side_t;

  localparam int IN_MAT [9] = '{
    59719, 35458, 4823,
    7600, 90834, 1566,
    2840, 13383, 83777
  };

  localparam int OUT_MAT [9] = '{
    160475, -53108, -7367,
    -10208, 110813, -605,
    -327, -7276, 107602
  };

  // round(n / d * 2^bits) by restoring long division, for elaboration only.
  function automatic logic [63:0] fixc(input logic [31:0] n, input logic [31:0] d,
                                       input int bits);
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] dd;
    r  = '0;
    q  = '0;
    dd = {32'd0, d};
    for (int i = 31; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      q = {q[62:0], 1'b0};
      if (r >= dd) begin
        r    = r - dd;
        q[0] = 1'b1;
      end
    end
    for (int i = 0; i < bits; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= dd) begin
        r    = r - dd;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= dd) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  function automatic logic [CINW-1:0] in_coef(input int k);
    return CINW'(fixc(32'(IN_MAT[k]), 32'd100000, COEF_BITS));
  endfunction

  function automatic logic signed [COUTW-1:0] out_coef(input int k);
    int                      n;
    logic signed [COUTW-1:0] v;
    n = OUT_MAT[k];
    v = COUTW'(fixc(32'((n < 0) ? -n : n), 32'd100000, COEF_BITS));
    return (n < 0) ? -v : v;
  endfunction

  // floor(255 * c / 2^f) for 0 <= c <= 2^f.
  function automatic logic [BYTE_W-1:0] to_byte(input logic [UW-1:0] c, input int f);
    logic [UW+BYTE_W-1:0] t;
    t = {c, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, c};
    return BYTE_W'(t >> f);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/atm_in_if.sv -----
// Input pixel channel: valid/ready handshake with four 8.16 channel fields.
// Depends on atm_pkg.
`default_nettype none

interface atm_in_if;
  import atm_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] red_in;
  logic [FIELD_W-1:0] green_in;
  logic [FIELD_W-1:0] blue_in;
  logic [FIELD_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/atm_out_if.sv -----
// Result pixel channel: valid/ready handshake with four byte fields.
// Depends on atm_pkg.
`default_nettype none

interface atm_out_if;
  import atm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic [BYTE_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/atm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, signed result.
// Depends on atm_pkg; stage loads are driven by the parent's stall chain.
`default_nettype none

module atm_div #(
  parameter int FRAC_BITS = atm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                              clk,
  input  logic [FRAC_BITS+atm_pkg::DIV_INT_BITS-1:0]        ld,
  input  logic [atm_pkg::DW-1:0]                            mag,
  input  logic [atm_pkg::DW-1:0]                            den,
  input  logic                                              neg,
  output logic signed [FRAC_BITS+atm_pkg::DIV_INT_BITS:0]   quo
);
  import atm_pkg::*;

  localparam int Q = FRAC_BITS + DIV_INT_BITS;

  logic [DW-1:0]           rem_r  [Q];
  logic [DW-1:0]           den_r  [Q];
  logic [Q-1:0]            quo_r  [Q];
  logic [DIV_INT_BITS-1:0] feed_r [Q];
  logic                    neg_r  [Q];

  for (genvar k = 0; k < Q; k++) begin : g_step
    logic [DW-1:0]           rem_i;
    logic [DW-1:0]           den_i;
    logic [Q-1:0]            quo_i;
    logic [DIV_INT_BITS-1:0] feed_i;
    logic                    neg_i;
    logic [DW:0]             trial;
    logic                    ge;

    if (k == 0) begin : g_first
      // The dividend is mag * 2^FRAC_BITS; its top part starts the remainder.
      assign rem_i  = mag >> DIV_INT_BITS;
      assign feed_i = mag[DIV_INT_BITS-1:0];
      assign quo_i  = '0;
      assign den_i  = den;
      assign neg_i  = neg;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign feed_i = feed_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign neg_i  = neg_r[k-1];
    end

    assign trial = {rem_i, feed_i[DIV_INT_BITS-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k]  <= ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
        quo_r[k]  <= {quo_i[Q-2:0], ge};
        feed_r[k] <= feed_i << 1;
        den_r[k]  <= den_i;
        neg_r[k]  <= neg_i;
      end
    end
  end

  assign quo = neg_r[Q-1] ? -$signed({1'b0, quo_r[Q-1]}) : $signed({1'b0, quo_r[Q-1]});

endmodule

`default_nettype wire

// ----- rtl/core/aces_tone_map_pixel_top.sv -----
// ACES-style tone mapper, one pixel word per clock sustained while the output accepts.
// The divider adds one stage per quotient bit.
// Throughput: one word per cycle unless the output stalls; a stall squeezes out bubbles.
// Reset (synchronous, active low) empties the pipeline and sets tone_mode to fitted.
`default_nettype none
`include "assert_macros.svh"

module aces_tone_map_pixel_top #(
  parameter int FRACTION_BITS = atm_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [atm_pkg::MODE_W-1:0]  cfg_wdata,
  atm_in_if.sink                      in_px,
  atm_out_if.source                   out_px
);
  import atm_pkg::*;

  // Pipeline map. Every stage is a register bank with its own valid bit:
  //   0        input matrix products (9 multipliers, shared by all modes)
  //   1        row sums, floor back to the data format; clamp-only mode clamps here
  //   2        curve scale products k*u
  //   3        inner sums k*u + m
  //   4        curve products u*(k*u + m)
  //   5        constant terms, numerator sign and magnitude, denominator
  //   6..      divider, one quotient bit per stage
  //   L_OP     output matrix products
  //   L_Z      row sums, floor and clamp to [0,1]
  //   L_OUT    scale by 255 into bytes; this is the output register
  // Clamp-only mode runs through the same datapath: the curve constants are set
  // so that the quotient equals the clamped input, and both matrices become
  // identities. The approximate mode uses the input matrix diagonal for 0.6.
  localparam int F     = FRACTION_BITS;
  localparam int Q     = F + DIV_INT_BITS;
  localparam int QW    = Q + 1;
  localparam int L_ND  = 5;
  localparam int L_DIV = 6;
  localparam int L_OP  = L_DIV + Q;
  localparam int L_Z   = L_OP + 1;
  localparam int L_OUT = L_OP + 2;
  localparam int NST   = L_OP + 3;
  localparam int PPW   = CINW + FIELD_W;
  localparam int OPW   = COUTW + QW;
  localparam int ZW    = OPW + 2 - COEF_BITS;

  localparam logic [UW-1:0]   ONE_U   = UW'(1) << F;
  localparam logic [CINW-1:0] ONE30   = CINW'(1) << COEF_BITS;
  localparam logic [CINW-1:0] S06     = CINW'(fixc(32'd6, 32'd10, COEF_BITS));

  localparam logic [KW-1:0]   K1_FIT  = KW'(1) << COEF_BITS;
  localparam logic [KW-1:0]   K1_APX  = KW'(fixc(32'd251, 32'd100, COEF_BITS));
  localparam logic [KW-1:0]   K2_FIT  = KW'(fixc(32'd983729, 32'd1000000, COEF_BITS));
  localparam logic [KW-1:0]   K2_APX  = KW'(fixc(32'd243, 32'd100, COEF_BITS));
  localparam logic [MW-1:0]   M1_FIT  = MW'(fixc(32'd245786, 32'd10000000, F));
  localparam logic [MW-1:0]   M1_APX  = MW'(fixc(32'd3, 32'd100, F));
  localparam logic [MW-1:0]   M1_CLP  = MW'(1) << F;
  localparam logic [MW-1:0]   M2_FIT  = MW'(fixc(32'd4329510, 32'd10000000, F));
  localparam logic [MW-1:0]   M2_APX  = MW'(fixc(32'd59, 32'd100, F));
  localparam logic [CW-1:0]   C1_FIT  = CW'(fixc(32'd90537, 32'd1000000000, 2 * F));
  localparam logic [CW-1:0]   C2_FIT  = CW'(fixc(32'd238081, 32'd1000000, 2 * F));
  localparam logic [CW-1:0]   C2_APX  = CW'(fixc(32'd14, 32'd100, 2 * F));
  localparam logic [CW-1:0]   C2_CLP  = CW'(1) << (2 * F);

  // Configuration register.
  tone_mode_t tone_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_mode_r <= MODE_FIT;
    end else if (cfg_we) begin
      tone_mode_r <= tone_mode_t'(cfg_wdata);
    end
  end

  // Stall chain: a stage loads when it is empty or when the stage after it loads.
  logic [NST-1:0] v_r;
  logic [NST-1:0] ld;
  atm_side_t      sb_r [NST];
  atm_side_t      sb_in;

  always_comb begin
    ld[NST-1] = !v_r[NST-1] || out_px.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_px.ready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= in_px.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Alpha is only clamped and scaled; its byte rides along with the mode.
  logic [UW-1:0] alpha_c;

  always_comb begin
    alpha_c = ({1'b0, in_px.alpha_in} > ONE_U) ? ONE_U : UW'(in_px.alpha_in);
    sb_in.mode  = tone_mode_r;
    sb_in.alpha = to_byte(alpha_c, F);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sb_r[0] <= sb_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (ld[k]) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // Stage 0: input matrix products.
  logic [FIELD_W-1:0] x_in    [3];
  logic [CINW-1:0]    cin_fit [3][3];
  logic [CINW-1:0]    cin_sel [3][3];
  logic [PPW-1:0]     pp_r    [3][3];

  assign x_in[0] = in_px.red_in;
  assign x_in[1] = in_px.green_in;
  assign x_in[2] = in_px.blue_in;

  for (genvar i = 0; i < 3; i++) begin : g_cin
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam logic [CINW-1:0] CIN = in_coef(i * 3 + j);
      assign cin_fit[i][j] = CIN;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        unique case (tone_mode_r)
          MODE_FIT:    cin_sel[i][j] = cin_fit[i][j];
          MODE_APPROX: cin_sel[i][j] = (i == j) ? S06 : '0;
          default:     cin_sel[i][j] = (i == j) ? ONE30 : '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= cin_sel[i][j] * x_in[j];
        end
      end
    end
  end

  // Stage 1: row sums floored to the data format.
  logic [PPW+1:0] rs      [3];
  logic [UW-1:0]  u_c     [3];
  logic [UW-1:0]  u1_r    [3];
  logic           clp1;

  assign clp1 = (sb_r[0].mode != MODE_FIT) && (sb_r[0].mode != MODE_APPROX);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i]  = (PPW+2)'(pp_r[i][0]) + (PPW+2)'(pp_r[i][1]) + (PPW+2)'(pp_r[i][2]);
      u_c[i] = rs[i][COEF_BITS +: UW];
      if (clp1 && (u_c[i] > ONE_U)) begin
        u_c[i] = ONE_U;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      u1_r <= u_c;
    end
  end

  // Stage 2: curve scale products.
  logic [KW-1:0]    k1_s, k2_s;
  logic [KW+UW-1:0] ka    [3];
  logic [KW+UW-1:0] kb    [3];
  logic [AW-1:0]    a2_r  [3];
  logic [AW-1:0]    b2_r  [3];
  logic [UW-1:0]    u2_r  [3];

  always_comb begin
    unique case (sb_r[1].mode)
      MODE_FIT: begin
        k1_s = K1_FIT;
        k2_s = K2_FIT;
      end
      MODE_APPROX: begin
        k1_s = K1_APX;
        k2_s = K2_APX;
      end
      default: begin
        k1_s = '0;
        k2_s = '0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      ka[i] = k1_s * u1_r[i];
      kb[i] = k2_s * u1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        a2_r[i] <= ka[i][COEF_BITS +: AW];
        b2_r[i] <= kb[i][COEF_BITS +: AW];
      end
      u2_r <= u1_r;
    end
  end

  // Stage 3: inner sums.
  logic [MW-1:0] m1_s, m2_s;
  logic [IW-1:0] in1_r [3];
  logic [IW-1:0] in2_r [3];
  logic [UW-1:0] u3_r  [3];

  always_comb begin
    unique case (sb_r[2].mode)
      MODE_FIT: begin
        m1_s = M1_FIT;
        m2_s = M2_FIT;
      end
      MODE_APPROX: begin
        m1_s = M1_APX;
        m2_s = M2_APX;
      end
      default: begin
        m1_s = M1_CLP;
        m2_s = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        in1_r[i] <= a2_r[i] + IW'(m1_s);
        in2_r[i] <= b2_r[i] + IW'(m2_s);
      end
      u3_r <= u2_r;
    end
  end

  // Stage 4: curve products.
  logic [PW-1:0] pn_r [3];
  logic [PW-1:0] pd_r [3];

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        pn_r[i] <= u3_r[i] * in1_r[i];
        pd_r[i] <= u3_r[i] * in2_r[i];
      end
    end
  end

  // Stage 5: constant terms. Only the fitted numerator can go negative.
  logic [CW-1:0] c1_s, c2_s;
  logic [NW-1:0] num  [3];
  logic [DW-1:0] mag5_r [3];
  logic [DW-1:0] den5_r [3];
  logic          neg5_r [3];

  always_comb begin
    unique case (sb_r[4].mode)
      MODE_FIT: begin
        c1_s = C1_FIT;
        c2_s = C2_FIT;
      end
      MODE_APPROX: begin
        c1_s = '0;
        c2_s = C2_APX;
      end
      default: begin
        c1_s = '0;
        c2_s = C2_CLP;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'(pn_r[i]) - NW'(c1_s);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[L_ND]) begin
      for (int i = 0; i < 3; i++) begin
        neg5_r[i] <= num[i][NW-1];
        mag5_r[i] <= num[i][NW-1] ? DW'(-num[i]) : DW'(num[i]);
        den5_r[i] <= DW'(pd_r[i]) + DW'(c2_s);
      end
    end
  end

  // Divider stages, one per channel, all moving under the same loads.
  logic signed [QW-1:0] q_d [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    atm_div #(
      .FRAC_BITS (F)
    ) u_div (
      .clk (clk),
      .ld  (ld[L_DIV +: Q]),
      .mag (mag5_r[i]),
      .den (den5_r[i]),
      .neg (neg5_r[i]),
      .quo (q_d[i])
    );
  end

  // Output matrix products; identity outside the fitted mode.
  logic signed [COUTW-1:0] cout_fit [3][3];
  logic signed [COUTW-1:0] cout_sel [3][3];
  logic signed [OPW-1:0]   po_r     [3][3];

  for (genvar i = 0; i < 3; i++) begin : g_cout
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam logic signed [COUTW-1:0] COUT = out_coef(i * 3 + j);
      assign cout_fit[i][j] = COUT;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (sb_r[L_OP-1].mode == MODE_FIT) begin
          cout_sel[i][j] = cout_fit[i][j];
        end else begin
          cout_sel[i][j] = (i == j) ? $signed(COUTW'(ONE30)) : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[L_OP]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          po_r[i][j] <= cout_sel[i][j] * q_d[j];
        end
      end
    end
  end

  // Row sums, floor by dropping the coefficient bits, clamp to [0,1].
  logic signed [OPW+1:0] zs  [3];
  logic [ZW-1:0]         zb  [3];
  logic [UW-1:0]         zc  [3];
  logic [UW-1:0]         c_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zs[i] = (OPW+2)'(po_r[i][0]) + (OPW+2)'(po_r[i][1]) + (OPW+2)'(po_r[i][2]);
      zb[i] = zs[i][OPW+1:COEF_BITS];
      if (zs[i][OPW+1]) begin
        zc[i] = '0;
      end else if (zb[i] > ZW'(ONE_U)) begin
        zc[i] = ONE_U;
      end else begin
        zc[i] = UW'(zb[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[L_Z]) begin
      c_r <= zc;
    end
  end

  // Output register: bytes.
  logic [BYTE_W-1:0] byte_r [3];

  always_ff @(posedge clk) begin
    if (ld[L_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        byte_r[i] <= to_byte(c_r[i], F);
      end
    end
  end

  assign out_px.valid     = v_r[NST-1];
  assign out_px.red_out   = byte_r[0];
  assign out_px.green_out = byte_r[1];
  assign out_px.blue_out  = byte_r[2];
  assign out_px.alpha_out = sb_r[NST-1].alpha;

  // The input only stalls when every stage holds a word and the output is blocked.
  `ATM_ASSERT_IMP(a_stall_full, clk, rst_n, !in_px.ready, (&v_r) && !out_px.ready, "input stalled with a bubble in the pipeline")
  // Words in flight change only by acceptances at either end.
  `ATM_ASSERT_NXT(a_no_loss, clk, rst_n, rst_n, $countones(v_r) == $past($countones(v_r)) + $past(in_px.valid && in_px.ready) - $past(out_px.valid && out_px.ready), "word count in the pipeline is inconsistent")
  // The curve denominator never reaches the divider as zero.
  `ATM_ASSERT_IMP(a_den_nonzero, clk, rst_n, v_r[L_ND], (den5_r[0] != 0) && (den5_r[1] != 0) && (den5_r[2] != 0), "zero denominator entered the divider")

endmodule

`default_nettype wire
